[design/double_ended_queue_defines.svh]
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define DQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/dq_pkg.sv]
package dq_pkg;

    // Field widths of the stream items
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // Input tdata: value, output tdata: front, back, count, padded to bytes
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * VAL_W - CNT_W;

    // Front and back report this when the queue holds nothing
    localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } t_state;

endpackage

[design/dq_ram.sv]
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [VAL_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [VAL_W-1:0] o_rd_data_a,
    output logic [VAL_W-1:0] o_rd_data_b
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_a;
    logic [VAL_W-1:0] r_rd_b;

    // One write port, two registered read ports (read returns old data)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[design/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring memory.
// Slave stream: tuser carries the command (push back, push front, pop front,
// pop back), tdata the value to push (ignored for pops).
// Master stream: one item per command; tdata holds the front value, the back
// value and the count after the command, tuser the status (done, pop on an
// empty queue ignored, push on a full queue dropped). Front and back read as
// all ones when the queue is empty.
// Each command writes the ring and then reads its front and back entries
// through the memory's registered read ports; a new command is taken only
// once the result of the last one has been loaded into the output register.
// The next command is accepted while the previous result still waits in the
// output register; if the receiver stalls, the finished read is held and the
// input stays blocked until the output register frees.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the ring contents are not cleared, as only filled entries are read.
`include "double_ended_queue_defines.svh"

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic [CMD_W-1:0]      s_axis_tuser,  // [1:0] command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] front, [63:32] back,
                                                 // [68:64] count, [71:69] zero
    output logic [STAT_W-1:0]     m_axis_tuser   // [1:0] status
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0]  LAST_POS   = AW'(DEPTH - 1);
    localparam logic [QCW-1:0] FULL_COUNT = QCW'(DEPTH);

    t_state r_state, n_state;

    logic [AW-1:0]  r_front, n_front;
    logic [AW-1:0]  r_back, n_back;
    logic [QCW-1:0] r_count, n_count;

    logic [AW-1:0] front_inc, front_dec, back_inc, back_dec, back_dec2;
    logic [AW-1:0] wr_addr, rd_back_addr;
    logic          wr_en;
    t_cmd          cmd;
    t_status       acc_status;
    logic          s_accept;
    logic          load_out;

    logic [VAL_W-1:0] ram_front, ram_back;

    // Held between the command cycle and the result cycle
    t_status          r_status;
    logic             r_fwd_front, r_fwd_back, r_empty_res;
    logic [VAL_W-1:0] r_push_val;

    // Output register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_front, r_out_back;
    logic [CNT_W-1:0] r_out_count;
    t_status          r_out_status;

    // Terms for the checks
    logic             full_push, empty_pop, idle_empty;

    assign cmd      = t_cmd'(s_axis_tuser);
    assign s_accept = s_axis_tvalid & s_axis_tready;

    // Ring neighbours of both positions
    always_comb begin
        front_inc = (r_front == LAST_POS) ? '0 : r_front + 1'b1;
        front_dec = (r_front == '0) ? LAST_POS : r_front - 1'b1;
        back_inc  = (r_back == LAST_POS) ? '0 : r_back + 1'b1;
        back_dec  = (r_back == '0) ? LAST_POS : r_back - 1'b1;
        back_dec2 = (back_dec == '0) ? LAST_POS : back_dec - 1'b1;
    end

    // Command decode: new positions, count, ring write and read addresses
    always_comb begin
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        acc_status   = STAT_DONE;
        wr_en        = 1'b0;
        wr_addr      = r_back;
        rd_back_addr = back_dec;
        unique case (cmd)
            CMD_PUSH_BACK: begin
                if (r_count == FULL_COUNT) begin
                    acc_status = STAT_FULL;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = r_back;
                    n_back       = back_inc;
                    n_count      = r_count + 1'b1;
                    rd_back_addr = r_back;
                end
            end
            CMD_PUSH_FRONT: begin
                if (r_count == FULL_COUNT) begin
                    acc_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    acc_status = STAT_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (r_count == '0) begin
                    acc_status = STAT_EMPTY;
                end else begin
                    n_back       = back_dec;
                    rd_back_addr = back_dec2;
                    n_count      = r_count - 1'b1;
                end
            end
            default: begin
                acc_status = STAT_DONE;
            end
        endcase
    end

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (s_accept & wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (s_axis_tdata),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (n_front),
        .i_rd_addr_b (rd_back_addr),
        .o_rd_data_a (ram_front),
        .o_rd_data_b (ram_back)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE:   s_axis_tready = 1'b1;
            S_RESULT: load_out      = !r_out_valid || m_axis_tready;
            default:  s_axis_tready = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-command payload; the pushed value bypasses the ring when the same
    // entry is read back in the write cycle
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_status    <= acc_status;
            r_fwd_front <= wr_en && (n_front == wr_addr);
            r_fwd_back  <= wr_en && (rd_back_addr == wr_addr);
            r_empty_res <= (n_count == '0);
            r_push_val  <= s_axis_tdata;
        end
        if (load_out) begin
            r_out_front  <= r_empty_res ? EMPTY_VALUE
                          : (r_fwd_front ? r_push_val : ram_front);
            r_out_back   <= r_empty_res ? EMPTY_VALUE
                          : (r_fwd_back ? r_push_val : ram_back);
            r_out_count  <= CNT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_count, r_out_back, r_out_front};
    assign m_axis_tuser  = r_out_status;

    // Checks
    assign full_push  = s_accept && (acc_status == STAT_FULL);
    assign empty_pop  = s_accept && (acc_status == STAT_EMPTY);
    assign idle_empty = (r_count == '0) && !r_out_valid && (r_state == S_IDLE);

    `DQ_ASSERT(a_count_bound, (r_count <= FULL_COUNT), "queue count above depth")
    `DQ_ASSERT(a_accept_to_result, (s_accept |=> (r_state == S_RESULT)), "no result cycle")
    `DQ_ASSERT(a_full_push_holds, (full_push |=> (r_count == FULL_COUNT)), "full push moved count")
    `DQ_ASSERT(a_empty_pop_holds, (empty_pop |=> (r_count == '0)), "empty pop moved count")
    `DQ_ASSERT_ALWAYS(a_reset_clears, (!i_rst_n |=> idle_empty), "reset did not empty the queue")

endmodule
